// ===== hdl/sra_pkg.sv =====
// Shared types and constants for the section RVA to file offset translator.
package sra_pkg;

    // Section table depth used when no other value is given
    localparam int MAX_SECTIONS_DEFAULT = 16;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int OFFS_W  = 33;
    localparam int IDX_W   = 4;
    localparam int CNT_CFG_W = 5;
    localparam int SRC_W   = 3;

    // Stream widths
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    // Configuration register indexes
    localparam logic CFG_HEADER_SIZE   = 1'b0;
    localparam logic CFG_SECTION_COUNT = 1'b1;

    // Input item kinds
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_LOAD      = 1'b1;

    // Result source codes
    localparam logic [SRC_W-1:0] SRC_ABSOLUTE = 3'd0;
    localparam logic [SRC_W-1:0] SRC_HEADER   = 3'd1;
    localparam logic [SRC_W-1:0] SRC_CACHE    = 3'd2;
    localparam logic [SRC_W-1:0] SRC_TABLE    = 3'd3;
    localparam logic [SRC_W-1:0] SRC_NONE     = 3'd4;

    // Lookup probe handed from cell to cell along the section chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [ADDR_W-1:0] rva;
        logic [ADDR_W-1:0] start_addr;
        logic [OFFS_W-1:0] end_addr;
        logic [ADDR_W-1:0] raw_ptr;
    } t_probe;

endpackage

// ===== hdl/sra_cell.sv =====
// One section table slot: holds a section's range and checks the passing probe against it.
module sra_cell
    import sra_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slot write
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_wr_start,
    input  logic [OFFS_W-1:0]    i_wr_end,
    input  logic [ADDR_W-1:0]    i_wr_ptr,
    // probe from the previous cell
    input  t_probe               i_probe,
    input  logic [CNT_W-1:0]     i_remaining,
    // probe to the next cell
    output t_probe               o_probe,
    output logic [CNT_W-1:0]     o_remaining
);

    logic [ADDR_W-1:0] r_start;
    logic [OFFS_W-1:0] r_end;
    logic [ADDR_W-1:0] r_ptr;

    t_probe            r_probe;
    logic [CNT_W-1:0]  r_remaining;

    logic              w_enabled;
    logic              w_match;

    // Slot contents, undefined until written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_start <= i_wr_start;
            r_end   <= i_wr_end;
            r_ptr   <= i_wr_ptr;
        end
    end

    // Slot takes part only while searched slots remain; first match wins
    assign w_enabled = (i_remaining != '0);
    assign w_match   = i_probe.valid && !i_probe.hit && w_enabled &&
                       (i_probe.rva >= r_start) && ({1'b0, i_probe.rva} < r_end);

    // Probe valid is reset; payload passes through or captures this slot on a match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= i_probe.valid;
        end
        r_probe.rva <= i_probe.rva;
        r_remaining <= w_enabled ? (i_remaining - 1'b1) : i_remaining;
        if (w_match) begin
            r_probe.hit        <= 1'b1;
            r_probe.start_addr <= r_start;
            r_probe.end_addr   <= r_end;
            r_probe.raw_ptr    <= r_ptr;
        end else begin
            r_probe.hit        <= i_probe.hit;
            r_probe.start_addr <= i_probe.start_addr;
            r_probe.end_addr   <= i_probe.end_addr;
            r_probe.raw_ptr    <= i_probe.raw_ptr;
        end
    end

    assign o_probe     = r_probe;
    assign o_remaining = r_remaining;

endmodule

// ===== hdl/section_rva_to_offset_translator.sv =====
// Top level: section RVA to file offset translator with a one-entry section cache.
// One item is in work at a time. From its transfer on the input stream, a table
// load, an absolute address or a header address is settled in the evaluate state
// and goes on to the done state; a cache hit passes through the add state first.
// A cache miss sends a probe down the chain of MAX_SECTIONS section cells, one
// cell per cycle; on a table hit the result then passes through the add state,
// and when no section covers the address it goes straight to the done state. The
// result waits in the done state until the output register is free. A new item is
// taken in the cycle after the previous result enters the output register, even
// while that result waits to be taken.
// Configuration writes are accepted in every cycle and belong in idle periods.
module section_rva_to_offset_translator
    import sra_pkg::*;
#(
    parameter int MAX_SECTIONS = MAX_SECTIONS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] rva, [32] absolute, [36:33] entry_index, [68:37] entry_virtual_start,
    // [100:69] entry_raw_size, [132:101] entry_raw_pointer, [135:133] zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // [0] kind
    input  logic                  i_s_tuser,
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [32:0] file_offset, [39:33] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // [0] found, [3:1] source
    output logic [M_TUSER_W-1:0]  o_m_tuser
);

    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_ADD    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;

    // configuration
    logic [ADDR_W-1:0]     r_header_size;
    logic [CNT_CFG_W-1:0]  r_section_count;

    // captured request
    logic                  r_kind;
    logic [ADDR_W-1:0]     r_rva;
    logic                  r_absolute;
    logic [IDX_W-1:0]      r_idx;
    logic [ADDR_W-1:0]     r_ld_start;
    logic [ADDR_W-1:0]     r_ld_size;
    logic [ADDR_W-1:0]     r_ld_ptr;

    // section cache
    logic [ADDR_W-1:0]     r_cache_start;
    logic [OFFS_W-1:0]     r_cache_end;
    logic [ADDR_W-1:0]     r_cache_ptr;

    // offset add operands and pending result
    logic [ADDR_W-1:0]     r_diff;
    logic [ADDR_W-1:0]     r_ptr;
    logic                  r_res_found;
    logic [OFFS_W-1:0]     r_res_off;
    logic [SRC_W-1:0]      r_res_src;

    // output register
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [OFFS_W-1:0]     r_out_off;
    logic [SRC_W-1:0]      r_out_src;

    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_out_load;
    logic                  w_is_load;
    logic                  w_hdr_hit;
    logic                  w_cache_hit;
    logic                  w_launch;
    logic [CNT_W-1:0]      w_count;
    logic [OFFS_W-1:0]     w_ld_end;
    t_probe                w_exit;

    t_probe                w_probe [0:MAX_SECTIONS];
    logic [CNT_W-1:0]      w_rem   [0:MAX_SECTIONS];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_xfer  = r_out_valid && i_m_tready;
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);

    // Decision terms for the item in evaluation
    assign w_is_load   = (r_kind == KIND_LOAD);
    assign w_hdr_hit   = (r_rva < r_header_size);
    assign w_cache_hit = (r_rva >= r_cache_start) && ({1'b0, r_rva} < r_cache_end);
    assign w_launch    = (r_state == ST_EVAL) && !w_is_load && !r_absolute &&
                         !w_hdr_hit && !w_cache_hit;

    // Searched slot count, limited to the table depth
    assign w_count = (32'(r_section_count) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                            : CNT_W'(r_section_count);

    // Section end kept in the cell so the walk needs only compares
    assign w_ld_end = {1'b0, r_ld_start} + {1'b0, r_ld_size};

    // Probe entering the chain
    assign w_probe[0] = '{valid: w_launch, hit: 1'b0, rva: r_rva,
                          start_addr: '0, end_addr: '0, raw_ptr: '0};
    assign w_rem[0]   = w_count;

    // Chain of section cells
    for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
        logic w_we;
        assign w_we = (r_state == ST_EVAL) && w_is_load && (32'(r_idx) == i);

        sra_cell #(
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_we        (w_we),
            .i_wr_start  (r_ld_start),
            .i_wr_end    (w_ld_end),
            .i_wr_ptr    (r_ld_ptr),
            .i_probe     (w_probe[i]),
            .i_remaining (w_rem[i]),
            .o_probe     (w_probe[i+1]),
            .o_remaining (w_rem[i+1])
        );
    end

    assign w_exit = w_probe[MAX_SECTIONS];

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (w_is_load || r_absolute || w_hdr_hit) n_state = ST_DONE;
                else if (w_cache_hit)                     n_state = ST_ADD;
                else                                      n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (w_exit.valid) n_state = w_exit.hit ? ST_ADD : ST_DONE;
            end
            ST_ADD: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_header_size   <= '0;
            r_section_count <= '0;
            r_cache_start   <= '0;
            r_cache_end     <= '0;
            r_cache_ptr     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEADER_SIZE:   r_header_size   <= i_cfg_data;
                    CFG_SECTION_COUNT: r_section_count <= i_cfg_data[CNT_CFG_W-1:0];
                    default:           r_header_size   <= r_header_size;
                endcase
            end
            // cache takes the walk's outcome, cleared on a miss
            if ((r_state == ST_SEARCH) && w_exit.valid) begin
                if (w_exit.hit) begin
                    r_cache_start <= w_exit.start_addr;
                    r_cache_end   <= w_exit.end_addr;
                    r_cache_ptr   <= w_exit.raw_ptr;
                end else begin
                    r_cache_start <= '0;
                    r_cache_end   <= '0;
                    r_cache_ptr   <= '0;
                end
            end
            if (w_out_load)      r_out_valid <= 1'b1;
            else if (w_out_xfer) r_out_valid <= 1'b0;
        end
    end

    // Request capture, offset arithmetic and result registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_kind     <= i_s_tuser;
            r_rva      <= i_s_tdata[31:0];
            r_absolute <= i_s_tdata[32];
            r_idx      <= i_s_tdata[36:33];
            r_ld_start <= i_s_tdata[68:37];
            r_ld_size  <= i_s_tdata[100:69];
            r_ld_ptr   <= i_s_tdata[132:101];
        end
        case (r_state)
            ST_EVAL: begin
                r_diff <= r_rva - r_cache_start;
                r_ptr  <= r_cache_ptr;
                if (w_is_load) begin
                    r_res_found <= 1'b1;
                    r_res_off   <= '0;
                    r_res_src   <= SRC_NONE;
                end else if (r_absolute) begin
                    r_res_found <= 1'b1;
                    r_res_off   <= {1'b0, r_rva};
                    r_res_src   <= SRC_ABSOLUTE;
                end else if (w_hdr_hit) begin
                    r_res_found <= 1'b1;
                    r_res_off   <= {1'b0, r_rva};
                    r_res_src   <= SRC_HEADER;
                end else begin
                    r_res_found <= 1'b1;
                    r_res_src   <= SRC_CACHE;
                end
            end
            ST_SEARCH: begin
                r_diff <= r_rva - w_exit.start_addr;
                r_ptr  <= w_exit.raw_ptr;
                if (w_exit.hit) begin
                    r_res_found <= 1'b1;
                    r_res_src   <= SRC_TABLE;
                end else begin
                    r_res_found <= 1'b0;
                    r_res_off   <= '0;
                    r_res_src   <= SRC_NONE;
                end
            end
            ST_ADD: begin
                r_res_off <= {1'b0, r_diff} + {1'b0, r_ptr};
            end
            default: begin
                r_res_found <= r_res_found;
            end
        endcase
        if (w_out_load) begin
            r_out_found <= r_res_found;
            r_out_off   <= r_res_off;
            r_out_src   <= r_res_src;
        end
    end

    // Output stream
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-OFFS_W){1'b0}}, r_out_off};
    assign o_m_tuser  = {r_out_src, r_out_found};

endmodule

// ===== bench/section_rva_to_offset_translator_tb.sv =====
// Self-checking bench for the section RVA to file offset translator.
module section_rva_to_offset_translator_tb;
    import sra_pkg::*;

    localparam int SECTIONS = MAX_SECTIONS_DEFAULT;
    // run guard: far above the slowest legal run (gap + chain walk + stall per item)
    localparam int WATCHDOG = 20_000_000;

    // one input item, unpacked into its fields
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] rva;
        logic              absolute;
        logic [IDX_W-1:0]  slot;
        logic [ADDR_W-1:0] vstart;
        logic [ADDR_W-1:0] rsize;
        logic [ADDR_W-1:0] rptr;
    } t_section_req;

    // one result item
    typedef struct packed {
        logic              found;
        logic [OFFS_W-1:0] offset;
        logic [SRC_W-1:0]  src;
    } t_xlat_result;

    // directed row: register settings, the item, and an optional typed-in answer
    typedef struct packed {
        logic [ADDR_W-1:0]    hdr;
        logic [CNT_CFG_W-1:0] cnt;
        t_section_req         req;
        logic                 typed;
        t_xlat_result         want;
    } t_dir_row;

    typedef enum int {LAYOUT_SPREAD, LAYOUT_WILD, LAYOUT_OVERLAP} t_layout;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    section_rva_to_offset_translator #(
        .MAX_SECTIONS(SECTIONS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // bench-side copy of the translator state
    logic [ADDR_W-1:0]    tbl_start [SECTIONS];
    logic [ADDR_W-1:0]    tbl_size  [SECTIONS];
    logic [ADDR_W-1:0]    tbl_ptr   [SECTIONS];
    logic [ADDR_W-1:0]    hdr_size;
    logic [CNT_CFG_W-1:0] sec_count;
    logic [ADDR_W-1:0]    hot_start;
    logic [OFFS_W-1:0]    hot_end;
    logic [ADDR_W-1:0]    hot_ptr;

    t_xlat_result pending_offsets [$];
    int           error_count;
    bit           tx_gaps;
    bit           rx_stalls;
    int           rx_hold;

    // directed items; typed answers only where they are obvious
    t_dir_row dir_rows [22] = '{
        // empty cache, zero header, no sections: plain miss
        '{32'h0, 5'd0, '{KIND_TRANSLATE, 32'h0, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b0, 33'h0, SRC_NONE}},
        // absolute requests at both ends of the address range
        '{32'h0, 5'd0, '{KIND_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b1, 33'h0_FFFF_FFFF, SRC_ABSOLUTE}},
        '{32'h0, 5'd0, '{KIND_TRANSLATE, 32'h0, 1'b1, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b1, 33'h0, SRC_ABSOLUTE}},
        // table loads: overlapping pair, empty section, wrapping section, all ones
        '{32'h0, 5'd0, '{KIND_LOAD, 32'h0, 1'b0, 4'd0, 32'h1000, 32'h200, 32'h400},
          1'b1, '{1'b1, 33'h0, SRC_NONE}},
        '{32'h0, 5'd0, '{KIND_LOAD, 32'h0, 1'b0, 4'd1, 32'h1100, 32'h300, 32'h8000},
          1'b1, '{1'b1, 33'h0, SRC_NONE}},
        '{32'h0, 5'd0, '{KIND_LOAD, 32'h0, 1'b0, 4'd2, 32'h3000, 32'h0, 32'h123},
          1'b1, '{1'b1, 33'h0, SRC_NONE}},
        '{32'h0, 5'd0, '{KIND_LOAD, 32'h0, 1'b0, 4'd3, 32'hFFFF_F000, 32'hFFFF_FFFF,
          32'hFFFF_FFFF}, 1'b1, '{1'b1, 33'h0, SRC_NONE}},
        '{32'h0, 5'd0, '{KIND_LOAD, 32'hFFFF_FFFF, 1'b1, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF}, 1'b1, '{1'b1, 33'h0, SRC_NONE}},
        // header region, then table hit, cache hits
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'hFFF, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b1, 33'hFFF, SRC_HEADER}},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h1000, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h1100, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h11FF, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h1200, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        // rewrite the cached slot: cache keeps the old section
        '{32'h1000, 5'd4, '{KIND_LOAD, 32'h0, 1'b0, 4'd1, 32'h5000, 32'h100, 32'h0},
          1'b1, '{1'b1, 33'h0, SRC_NONE}},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h1300, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        // empty section never matches; miss clears the cache
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h3000, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b0, 33'h0, SRC_NONE}},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'h1300, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b0, 33'h0, SRC_NONE}},
        // wrapping section at the top: largest offsets
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        '{32'h1000, 5'd4, '{KIND_TRANSLATE, 32'hFFFF_F000, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b0, '0},
        // header covering all but the top address
        '{32'hFFFF_FFFF, 5'd4, '{KIND_TRANSLATE, 32'hFFFF_FFFE, 1'b0, 4'd0, 32'h0, 32'h0,
          32'h0}, 1'b1, '{1'b1, 33'h0_FFFF_FFFE, SRC_HEADER}},
        '{32'hFFFF_FFFF, 5'd4, '{KIND_TRANSLATE, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'h0, 32'h0,
          32'h0}, 1'b0, '0},
        '{32'h0, 5'd4, '{KIND_TRANSLATE, 32'h0, 1'b0, 4'd0, 32'h0, 32'h0, 32'h0},
          1'b1, '{1'b0, 33'h0, SRC_NONE}}
    };

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // expected result of one item; updates the bench copy of the state
    function automatic t_xlat_result lookup_offset(input t_section_req r);
        t_xlat_result      res;
        logic [OFFS_W-1:0] sec_end;
        int                live;
        int                i;
        res.found  = 1'b1;
        res.offset = '0;
        res.src    = SRC_NONE;
        if (r.kind == KIND_LOAD) begin
            tbl_start[r.slot] = r.vstart;
            tbl_size[r.slot]  = r.rsize;
            tbl_ptr[r.slot]   = r.rptr;
            return res;
        end
        if (r.absolute) begin
            res.offset = {1'b0, r.rva};
            res.src    = SRC_ABSOLUTE;
            return res;
        end
        if (r.rva < hdr_size) begin
            res.offset = {1'b0, r.rva};
            res.src    = SRC_HEADER;
            return res;
        end
        if (r.rva >= hot_start && {1'b0, r.rva} < hot_end) begin
            res.offset = {1'b0, r.rva} - {1'b0, hot_start} + {1'b0, hot_ptr};
            res.src    = SRC_CACHE;
            return res;
        end
        // counts above the table depth search the whole table
        live = (sec_count > SECTIONS) ? SECTIONS : int'(sec_count);
        for (i = 0; i < live; i++) begin
            sec_end = {1'b0, tbl_start[i]} + {1'b0, tbl_size[i]};
            if (r.rva >= tbl_start[i] && {1'b0, r.rva} < sec_end) begin
                hot_start  = tbl_start[i];
                hot_end    = sec_end;
                hot_ptr    = tbl_ptr[i];
                res.offset = {1'b0, r.rva} - {1'b0, tbl_start[i]} + {1'b0, tbl_ptr[i]};
                res.src    = SRC_TABLE;
                return res;
            end
        end
        hot_start = '0;
        hot_end   = '0;
        hot_ptr   = '0;
        res.found = 1'b0;
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_cycles(input bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // table load item shaped by the layout
    function automatic t_section_req make_section(input t_layout layout,
                                                  input logic [IDX_W-1:0] slot);
        t_section_req r;
        r.kind     = KIND_LOAD;
        r.rva      = $urandom;
        r.absolute = 1'($urandom);
        r.slot     = slot;
        r.rptr     = $urandom;
        case (layout)
            LAYOUT_SPREAD: begin
                // one disjoint section per 64K window
                r.vstart = {12'h000, slot, 16'h0000} + $urandom_range(0, 255);
                r.rsize  = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(16, 32'h8000);
            end
            LAYOUT_WILD: begin
                r.vstart = $urandom;
                r.rsize  = $urandom >> $urandom_range(0, 31);
            end
            default: begin
                // sections piled on top of each other
                r.vstart = 32'h0002_0000 + $urandom_range(0, 32'h3FFF);
                r.rsize  = $urandom_range(0, 32'h4000);
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OFFS_W-1:0] got,
                                   input logic [OFFS_W-1:0] want);
        if (error_count < 100)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // both registers, back to back, valid held high between them
    task automatic program_regs(input logic [ADDR_W-1:0] hdr, input logic [CNT_CFG_W-1:0] cnt);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HEADER_SIZE;
        i_cfg_data  <= hdr;
        do @(posedge i_clk); while (!o_cfg_ready);
        hdr_size = hdr;
        i_cfg_index <= CFG_SECTION_COUNT;
        i_cfg_data  <= {{(ADDR_W-CNT_CFG_W){1'b0}}, cnt};
        do @(posedge i_clk); while (!o_cfg_ready);
        sec_count = cnt;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // hold the input stream until every outstanding result is back
    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_offsets.size() != 0);
    endtask

    task automatic send_item(input t_section_req r, input bit use_typed,
                             input t_xlat_result typed);
        t_xlat_result predicted;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.kind;
        i_s_tdata  <= {3'b000, r.rptr, r.rsize, r.vstart, r.slot, r.absolute, r.rva};
        do @(posedge i_clk); while (!o_s_tready);
        predicted = lookup_offset(r);
        pending_offsets.push_back(use_typed ? typed : predicted);
    endtask

    // refill the table, then a random mix in which the largest share aims inside sections
    task automatic run_phase(input logic [ADDR_W-1:0] hdr, input logic [CNT_CFG_W-1:0] cnt,
                             input t_layout layout, input bit gaps, input bit stalls,
                             input int count);
        t_section_req      r;
        int                live;
        int                focus;
        int                roll;
        int                k;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] sz;
        wait_all_results();
        program_regs(hdr, cnt);
        tx_gaps   = gaps;
        rx_stalls = stalls;
        live  = (cnt > SECTIONS) ? SECTIONS : int'(cnt);
        focus = 0;
        for (k = 0; k < SECTIONS + count; k++) begin
            r.kind     = KIND_TRANSLATE;
            r.rva      = $urandom;
            r.absolute = 1'b0;
            r.slot     = 4'($urandom);
            r.vstart   = $urandom;
            r.rsize    = $urandom;
            r.rptr     = $urandom;
            roll = $urandom_range(0, 99);
            if (k < SECTIONS) begin
                r = make_section(layout, 4'(k));
            end else if (roll < 8) begin
                r = make_section(layout, 4'($urandom));
            end else if (roll < 16) begin
                r.absolute = 1'b1;
            end else if (roll < 26) begin
                if (hdr != 0) r.rva = $urandom % hdr;
            end else if (roll < 80 && live > 0) begin
                // runs within one section give cache hits
                if ($urandom_range(0, 9) < 3) focus = $urandom_range(0, live - 1);
                lo = tbl_start[focus];
                sz = tbl_size[focus];
                if (roll < 72) begin
                    r.rva = lo + ((sz == 0) ? 32'd0 : $urandom % sz);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       r.rva = lo - 1;
                        1:       r.rva = lo + sz;
                        default: r.rva = lo + sz - 1;
                    endcase
                end
            end
            pause_sender(idle_cycles(tx_gaps));
            send_item(r, 1'b0, '0);
            if ($urandom_range(0, 149) == 0) wait_all_results();
        end
    endtask

    // result side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin : result_side
        t_xlat_result got;
        t_xlat_result want;
        int           n;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.found  = o_m_tuser[0];
                got.src    = o_m_tuser[3:1];
                got.offset = o_m_tdata[OFFS_W-1:0];
                if (pending_offsets.size() == 0) begin
                    report_mismatch("result with nothing pending", got.offset, '0);
                end else begin
                    want = pending_offsets.pop_front();
                    if (got.found !== want.found)
                        report_mismatch("found", OFFS_W'(got.found), OFFS_W'(want.found));
                    if (got.offset !== want.offset)
                        report_mismatch("file_offset", got.offset, want.offset);
                    if (got.src !== want.src)
                        report_mismatch("source", OFFS_W'(got.src), OFFS_W'(want.src));
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else begin
                n = idle_cycles(rx_stalls);
                if (n > 0) begin
                    rx_hold = n - 1;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_HEADER_SIZE;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= KIND_TRANSLATE;
        hdr_size    = '0;
        sec_count   = '0;
        hot_start   = '0;
        hot_end     = '0;
        hot_ptr     = '0;
        error_count = 0;
        rx_hold     = 0;
        tx_gaps     = 1'b1;
        rx_stalls   = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].hdr !== hdr_size || dir_rows[k].cnt !== sec_count) begin
                wait_all_results();
                program_regs(dir_rows[k].hdr, dir_rows[k].cnt);
            end
            pause_sender(idle_cycles(tx_gaps));
            send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        end

        run_phase(32'h0, 5'd16, LAYOUT_SPREAD, 1'b0, 1'b0, 210);
        run_phase(32'hFFFF_FFFF, 5'd16, LAYOUT_WILD, 1'b1, 1'b1, 210);
        run_phase(32'h400, 5'd31, LAYOUT_OVERLAP, 1'b0, 1'b1, 210);
        run_phase(32'h1_0000, 5'd1, LAYOUT_SPREAD, 1'b1, 1'b0, 210);
        run_phase($urandom >> 8, 5'd17, LAYOUT_WILD, 1'b1, 1'b1, 210);
        run_phase(32'h0, 5'd0, LAYOUT_OVERLAP, 1'b1, 1'b1, 120);
        repeat (3)
            run_phase($urandom_range(0, 32'h2_0000), 5'($urandom_range(0, 31)),
                      t_layout'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 200);

        // let any stray result show up
        wait_all_results();
        repeat (SECTIONS + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("section_rva_to_offset_translator_tb: done, clean");
        else
            $display("section_rva_to_offset_translator_tb: done, errors");
        $finish;
    end

    // hang guard
    initial begin
        #(WATCHDOG);
        $display("section_rva_to_offset_translator_tb: done, errors");
        $finish;
    end

endmodule
